// ===== hdl/pccb_pkg.sv =====
// ----------------------------------------------------------------------------
// Paired coil current balancer package
// Shared widths, register codes and payload types.
// ----------------------------------------------------------------------------
package pccb_pkg;

	localparam int CUR_W     = 16;
	localparam int DUTY_W    = 16;
	localparam int ERR_W     = 17;
	localparam int GAIN_W    = 16;
	localparam int MPLIER_W  = 16;
	localparam int TRIM_W    = 34;
	localparam int ACC_W     = 50;
	localparam int NUM_CH    = 4;
	localparam int NUM_PAIRS = 2;
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;

	localparam logic [2:0] REG_ENABLE     = 3'd0;
	localparam logic [2:0] REG_PROP_GAIN  = 3'd1;
	localparam logic [2:0] REG_INT_GAIN   = 3'd2;
	localparam logic [2:0] REG_DEAD_BAND  = 3'd3;
	localparam logic [2:0] REG_TRIM_LIMIT = 3'd4;
	localparam logic [2:0] REG_DUTY_MIN   = 3'd5;
	localparam logic [2:0] REG_CEILINGS   = 3'd6;
	localparam logic [2:0] REG_PAIR_MAP   = 3'd7;

	typedef logic [CUR_W-1:0]         cur_t;
	typedef logic [DUTY_W-1:0]        duty_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [TRIM_W-1:0] trim_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

// ===== hdl/pccb_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle, LSB first; adder as wide as the
// multiplicand plus one.
// ----------------------------------------------------------------------------
module pccb_serial_mul #(
	parameter int MCAND_W = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [MCAND_W-1:0]                mcand,
	input  logic [pccb_pkg::MPLIER_W-1:0]     mplier,
	output logic                              busy,
	output logic [MCAND_W+pccb_pkg::MPLIER_W-1:0] product
);
	import pccb_pkg::*;

	localparam int CNT_W = $clog2(MPLIER_W + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic [MCAND_W-1:0]  mc_q;
	logic [MCAND_W-1:0]  hi_q;
	logic [MPLIER_W-1:0] lo_q;
	logic [MCAND_W:0]    sum;

	assign busy    = cnt_q != '0;
	assign sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);
	assign product = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(MPLIER_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= mplier;
			mc_q <= mcand;
		end else if (busy) begin
			hi_q <= sum[MCAND_W:1];
			lo_q <= {sum[0], lo_q[MPLIER_W-1:1]};
		end
	end

endmodule

// ===== hdl/paired_coil_current_balancer_top.sv =====
// ----------------------------------------------------------------------------
// Paired coil current balancer
// PI balancing of two coil pairs with deadband, trim clamp and duty limits.
//
//   channel   handshake                  payload
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//   tick      tick_valid/tick_ready      current_a..current_d, dt_ms
//   result    result_valid/result_ready  duty_a..duty_d, error_first,
//                                        error_second, actuated
//
// An actuating tick (enabled, dt_ms nonzero) first forms int_gain*dt_ms and
// then handles each pair in turn on the two 16-step serial multipliers.
// A tick that does not actuate goes straight to the result.
// tick_ready stays high while a finished result waits; the next tick stalls
// only at its end if result_ready is still low.
// Reset clears configuration, trims, applied duties, pair errors and state.
// ----------------------------------------------------------------------------
module paired_coil_current_balancer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pccb_pkg::PADDR_W-1:0]  paddr,
	input  logic [pccb_pkg::PDATA_W-1:0]  pwdata,
	output logic [pccb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  pccb_pkg::cur_t                current_a,
	input  pccb_pkg::cur_t                current_b,
	input  pccb_pkg::cur_t                current_c,
	input  pccb_pkg::cur_t                current_d,
	input  logic [15:0]                   dt_ms,
	output logic                          result_valid,
	input  logic                          result_ready,
	output pccb_pkg::duty_t               duty_a,
	output pccb_pkg::duty_t               duty_b,
	output pccb_pkg::duty_t               duty_c,
	output pccb_pkg::duty_t               duty_d,
	output pccb_pkg::err_t                error_first,
	output pccb_pkg::err_t                error_second,
	output logic                          actuated
);
	import pccb_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL1   = 4'd1;
	localparam logic [3:0] S_ERR    = 4'd2;
	localparam logic [3:0] S_MUL2   = 4'd3;
	localparam logic [3:0] S_INTEG  = 4'd4;
	localparam logic [3:0] S_TCLAMP = 4'd5;
	localparam logic [3:0] S_CMD    = 4'd6;
	localparam logic [3:0] S_CCLAMP = 4'd7;
	localparam logic [3:0] S_ROUND  = 4'd8;
	localparam logic [3:0] S_DUTY   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	function automatic trim_t clamp_lim(acc_t v, acc_t lim);
		acc_t r;
		if (v < -lim) begin
			r = -lim;
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r[TRIM_W-1:0];
	endfunction

	// configuration
	logic                 enable_q;
	logic [GAIN_W-1:0]    prop_gain_q;
	logic [GAIN_W-1:0]    int_gain_q;
	logic [15:0]          dead_band_q;
	logic [15:0]          trim_limit_q;
	duty_t                duty_min_q;
	logic [63:0]          ceilings_q;
	logic [7:0]           pair_map_q;

	// control and state
	logic [3:0]           state_q;
	logic                 k_q;
	logic                 act_pend_q;
	logic                 result_valid_q;
	trim_t                trim_q [NUM_PAIRS];
	duty_t                applied_q [NUM_CH];
	err_t                 pair_error_q [NUM_PAIRS];

	// datapath
	cur_t                 cur_q [NUM_CH];
	logic [31:0]          m1_q;
	logic                 err_neg_q;
	logic [15:0]          mag_q;
	logic                 integ_q;
	acc_t                 sum_q;
	acc_t                 csum_q;
	trim_t                cmd_q;
	logic [16:0]          r_q;
	logic                 pos_q;
	logic                 neg_q;

	// result register
	duty_t                duty_q [NUM_CH];
	err_t                 err_first_q;
	err_t                 err_second_q;
	logic                 act_q;

	logic                 cfg_wr;
	logic [2:0]           cfg_idx;
	logic                 tick_xfer;
	logic                 go;
	logic                 out_load;
	logic [1:0]           p_sel;
	logic [1:0]           q_sel;
	logic [ERR_W-1:0]     err_c;
	logic [ERR_W-1:0]     mag_full;
	logic [15:0]          mag_c;
	logic                 nm_start;
	logic [GAIN_W-1:0]    nm_mcand;
	logic [MPLIER_W-1:0]  nm_mplier;
	logic                 nm_busy;
	logic [31:0]          nm_product;
	logic                 wm_busy;
	logic [47:0]          wm_product;
	trim_t                trim_k;
	acc_t                 trim_ext;
	acc_t                 m2_s;
	acc_t                 sprod;
	acc_t                 p8;
	acc_t                 pterm;
	acc_t                 lim_s;
	trim_t                amag;
	logic [32:0]          rsum;
	duty_t                cp;
	duty_t                cq;
	logic signed [17:0]   dp_c;
	logic signed [17:0]   dq_c;
	logic signed [17:0]   fl_s;
	duty_t                dp_fin;
	duty_t                dq_fin;

	assign pready     = 1'b1;
	assign cfg_wr     = psel & penable & pwrite;
	assign cfg_idx    = paddr[PADDR_W-1 -: 3];
	assign tick_ready = state_q == S_IDLE;
	assign tick_xfer  = tick_valid & tick_ready;
	assign go         = enable_q & (dt_ms != '0);
	assign out_load   = (state_q == S_DONE) & (~result_valid_q | result_ready);

	always_comb begin
		unique case (cfg_idx)
			REG_ENABLE:     prdata = PDATA_W'(enable_q);
			REG_PROP_GAIN:  prdata = PDATA_W'(prop_gain_q);
			REG_INT_GAIN:   prdata = PDATA_W'(int_gain_q);
			REG_DEAD_BAND:  prdata = PDATA_W'(dead_band_q);
			REG_TRIM_LIMIT: prdata = PDATA_W'(trim_limit_q);
			REG_DUTY_MIN:   prdata = PDATA_W'(duty_min_q);
			REG_CEILINGS:   prdata = PDATA_W'(ceilings_q);
			REG_PAIR_MAP:   prdata = PDATA_W'(pair_map_q);
			default:        prdata = '0;
		endcase
	end

	// pair selection and error
	assign p_sel    = k_q ? pair_map_q[5:4] : pair_map_q[1:0];
	assign q_sel    = k_q ? pair_map_q[7:6] : pair_map_q[3:2];
	assign err_c    = {1'b0, cur_q[p_sel]} - {1'b0, cur_q[q_sel]};
	assign mag_full = err_c[ERR_W-1] ? (ERR_W'(0) - err_c) : err_c;
	assign mag_c    = mag_full[15:0];

	// multipliers
	assign nm_start  = (tick_xfer & go) | (state_q == S_ERR);
	assign nm_mcand  = (state_q == S_IDLE) ? int_gain_q : prop_gain_q;
	assign nm_mplier = (state_q == S_IDLE) ? dt_ms : mag_c;

	pccb_serial_mul #(
		.MCAND_W(GAIN_W)
	) u_mul_narrow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nm_start),
		.mcand  (nm_mcand),
		.mplier (nm_mplier),
		.busy   (nm_busy),
		.product(nm_product)
	);

	pccb_serial_mul #(
		.MCAND_W(32)
	) u_mul_wide (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_ERR),
		.mcand  (m1_q),
		.mplier (mag_c),
		.busy   (wm_busy),
		.product(wm_product)
	);

	// integrator and command
	assign trim_k   = trim_q[k_q];
	assign trim_ext = {{(ACC_W-TRIM_W){trim_k[TRIM_W-1]}}, trim_k};
	assign m2_s     = $signed({2'b0, wm_product});
	assign sprod    = err_neg_q ? -m2_s : m2_s;
	assign p8       = $signed({10'b0, nm_product, 8'b0});
	assign pterm    = err_neg_q ? -p8 : p8;
	assign lim_s    = $signed({18'b0, trim_limit_q, 16'b0});
	assign amag     = cmd_q[TRIM_W-1] ? -cmd_q : cmd_q;
	assign rsum     = {1'b0, amag[31:0]} + 33'h0_8000;

	// duties
	assign cp     = ceilings_q[{p_sel, 4'b0000} +: DUTY_W];
	assign cq     = ceilings_q[{q_sel, 4'b0000} +: DUTY_W];
	assign fl_s   = $signed({2'b0, duty_min_q});
	assign dp_c   = $signed({2'b0, cp}) - $signed({1'b0, pos_q ? r_q : 17'd0});
	assign dq_c   = $signed({2'b0, cq}) - $signed({1'b0, neg_q ? r_q : 17'd0});
	assign dp_fin = (dp_c < fl_s) ? duty_min_q : dp_c[DUTY_W-1:0];
	assign dq_fin = (dq_c < fl_s) ? duty_min_q : dq_c[DUTY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			prop_gain_q    <= '0;
			int_gain_q     <= '0;
			dead_band_q    <= '0;
			trim_limit_q   <= '0;
			duty_min_q     <= '0;
			ceilings_q     <= '0;
			pair_map_q     <= '0;
			state_q        <= S_IDLE;
			k_q            <= 1'b0;
			act_pend_q     <= 1'b0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < NUM_PAIRS; i++) begin
				trim_q[i]       <= '0;
				pair_error_q[i] <= '0;
			end
			for (int i = 0; i < NUM_CH; i++) begin
				applied_q[i] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_ENABLE: begin
						if (pwdata[0] && !enable_q) begin
							for (int i = 0; i < NUM_PAIRS; i++) begin
								trim_q[i] <= '0;
							end
							for (int i = 0; i < NUM_CH; i++) begin
								applied_q[i] <= ceilings_q[i*DUTY_W +: DUTY_W];
							end
						end
						enable_q <= pwdata[0];
					end
					REG_PROP_GAIN:  prop_gain_q  <= pwdata[GAIN_W-1:0];
					REG_INT_GAIN:   int_gain_q   <= pwdata[GAIN_W-1:0];
					REG_DEAD_BAND:  dead_band_q  <= pwdata[15:0];
					REG_TRIM_LIMIT: trim_limit_q <= pwdata[15:0];
					REG_DUTY_MIN:   duty_min_q   <= pwdata[DUTY_W-1:0];
					REG_CEILINGS:   ceilings_q   <= pwdata[63:0];
					REG_PAIR_MAP:   pair_map_q   <= pwdata[7:0];
					default: ;
				endcase
			end

			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (tick_xfer) begin
						act_pend_q <= go;
						k_q        <= 1'b0;
						state_q    <= go ? S_MUL1 : S_DONE;
					end
				end
				S_MUL1: begin
					if (!nm_busy) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					pair_error_q[k_q] <= err_c;
					state_q           <= S_MUL2;
				end
				S_MUL2: begin
					if (!wm_busy) begin
						state_q <= S_INTEG;
					end
				end
				S_INTEG:  state_q <= S_TCLAMP;
				S_TCLAMP: begin
					if (integ_q) begin
						trim_q[k_q] <= clamp_lim(sum_q, lim_s);
					end
					state_q <= S_CMD;
				end
				S_CMD:    state_q <= S_CCLAMP;
				S_CCLAMP: state_q <= S_ROUND;
				S_ROUND:  state_q <= S_DUTY;
				S_DUTY: begin
					// same coil on both sides: the q duty stands
					if (p_sel != q_sel) begin
						applied_q[p_sel] <= dp_fin;
					end
					applied_q[q_sel] <= dq_fin;
					k_q              <= 1'b1;
					state_q          <= k_q ? S_DONE : S_ERR;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_xfer) begin
			cur_q[0] <= current_a;
			cur_q[1] <= current_b;
			cur_q[2] <= current_c;
			cur_q[3] <= current_d;
		end
		if (state_q == S_MUL1) begin
			m1_q <= nm_product;
		end
		if (state_q == S_ERR) begin
			err_neg_q <= err_c[ERR_W-1];
			mag_q     <= mag_c;
		end
		if (state_q == S_INTEG) begin
			integ_q <= mag_q > dead_band_q;
			sum_q   <= trim_ext + sprod;
		end
		if (state_q == S_CMD) begin
			csum_q <= trim_ext + pterm;
		end
		if (state_q == S_CCLAMP) begin
			cmd_q <= clamp_lim(csum_q, lim_s);
		end
		if (state_q == S_ROUND) begin
			r_q   <= rsum[32:16];
			pos_q <= !cmd_q[TRIM_W-1] && (cmd_q != '0);
			neg_q <= cmd_q[TRIM_W-1];
		end
		if (out_load) begin
			for (int i = 0; i < NUM_CH; i++) begin
				duty_q[i] <= applied_q[i];
			end
			err_first_q  <= pair_error_q[0];
			err_second_q <= pair_error_q[1];
			act_q        <= act_pend_q;
		end
	end

	assign result_valid = result_valid_q;
	assign duty_a       = duty_q[0];
	assign duty_b       = duty_q[1];
	assign duty_c       = duty_q[2];
	assign duty_d       = duty_q[3];
	assign error_first  = err_first_q;
	assign error_second = err_second_q;
	assign actuated     = act_q;

endmodule

// ===== hdl/pccb_checker.sv =====
// ----------------------------------------------------------------------------
// Paired coil current balancer checker
// Port-level properties of the tick, result and configuration channels.
// ----------------------------------------------------------------------------
module pccb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pccb_pkg::PADDR_W-1:0]  paddr,
	input  logic [pccb_pkg::PDATA_W-1:0]  pwdata,
	input  logic [pccb_pkg::PDATA_W-1:0]  prdata,
	input  logic                          tick_valid,
	input  logic                          tick_ready,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  pccb_pkg::duty_t               duty_a,
	input  pccb_pkg::err_t                error_first,
	input  logic                          actuated
);
	import pccb_pkg::*;

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick_ready high right after a tick transfer");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		tick_ready && !tick_valid && !result_valid |=> !result_valid)
		else $error("result appeared without a tick");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(duty_a) && $stable(error_first) && $stable(actuated))
		else $error("stalled result changed");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite) && paddr == $past(paddr) &&
			paddr[PADDR_W-1 -: 3] == REG_DUTY_MIN
		|-> prdata[15:0] == $past(pwdata[15:0]) && prdata[PDATA_W-1:16] == '0)
		else $error("duty_min readback differs from written value");

endmodule

bind paired_coil_current_balancer_top pccb_checker u_pccb_checker (.*);
